// ----- sv/nsv_pkg.sv -----
// ----------------------------------------------------------------------------
// nsv_pkg
// shared characters, status codes and the result word layout for the
// nmea sentence validator
// ----------------------------------------------------------------------------
package nsv_pkg;

	localparam logic [7:0] CH_DOLLAR      = 8'h24;
	localparam logic [7:0] CH_STAR        = 8'h2A;
	localparam logic [7:0] CH_COMMA       = 8'h2C;
	localparam logic [7:0] CH_LF          = 8'h0A;
	localparam logic [7:0] CH_CR          = 8'h0D;

	localparam logic [7:0] MIN_LINE       = 8'd7;
	localparam logic [7:0] MAX_LINE_RESET = 8'd150;
	localparam logic [3:0] MAX_HEX_DIGITS = 4'd8;
	localparam logic [7:0] SUM_SATURATED  = 8'hFF;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 80;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_NO_DOLLAR = 3'd2,
		ST_NO_STAR   = 3'd3,
		ST_BAD_SUM   = 3'd4
	} status_t;

	// first member lands in the top bits, status in the lowest bits
	typedef struct packed {
		logic [7:0] computed_sum;
		logic [7:0] received_sum;
		logic [7:0] line_length;
		logic [7:0] field_count;
		logic [7:0] type_third;
		logic [7:0] type_second;
		logic [7:0] type_first;
		logic [7:0] talker_second;
		logic [7:0] talker_first;
		status_t    status;
	} res_t;

	localparam int RES_W = $bits(res_t);

	// msb set when the character is a hex digit, low nibble is its value
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// ----- sv/nsv_line_tracker.sv -----
// ----------------------------------------------------------------------------
// nsv_line_tracker
// per-line running state, updated once per character, and the result of a
// line formed from that state when LF arrives
// ----------------------------------------------------------------------------
module nsv_line_tracker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        max_line_len,
	output logic              line_end,
	output nsv_pkg::res_t     res
);
	import nsv_pkg::*;

	logic [7:0] cnt_q;
	logic       dollar_q;
	logic       star_q;
	logic [7:0] xor_q;
	logic [7:0] talk_q [2];
	logic [7:0] type_q [3];
	logic       type_done_q;
	logic [7:0] comma_q;
	logic [7:0] hexv_q;
	logic [3:0] hexd_q;
	logic       hexstop_q;

	logic       is_cr;
	logic       is_lf;
	logic       overflow;
	logic [7:0] p;
	logic [4:0] hex;
	logic [7:0] rx_sum;

	assign is_cr    = (rx_byte == CH_CR);
	assign is_lf    = (rx_byte == CH_LF);
	assign line_end = is_lf && (cnt_q != 8'd0);
	assign overflow = ({1'b0, cnt_q} + 9'd1) > {1'b0, max_line_len};
	assign p        = cnt_q - 8'd1;
	assign hex      = hex_of(rx_byte);
	assign rx_sum   = (hexd_q > MAX_HEX_DIGITS) ? SUM_SATURATED : hexv_q;

	always_comb begin
		res.computed_sum  = xor_q;
		res.received_sum  = rx_sum;
		res.line_length   = cnt_q;
		res.field_count   = (comma_q == 8'd0) ? 8'd1 : comma_q;
		res.type_third    = type_q[2];
		res.type_second   = type_q[1];
		res.type_first    = type_q[0];
		res.talker_second = talk_q[1];
		res.talker_first  = talk_q[0];
		if (cnt_q < MIN_LINE) begin
			res.status = ST_SHORT;
		end else if (!dollar_q) begin
			res.status = ST_NO_DOLLAR;
		end else if (!star_q) begin
			res.status = ST_NO_STAR;
		end else if (rx_sum != xor_q) begin
			res.status = ST_BAD_SUM;
		end else begin
			res.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			dollar_q    <= 1'b0;
			star_q      <= 1'b0;
			xor_q       <= '0;
			talk_q[0]   <= '0;
			talk_q[1]   <= '0;
			type_q[0]   <= '0;
			type_q[1]   <= '0;
			type_q[2]   <= '0;
			type_done_q <= 1'b0;
			comma_q     <= '0;
			hexv_q      <= '0;
			hexd_q      <= '0;
			hexstop_q   <= 1'b0;
		end else if (en && !is_cr) begin
			if (is_lf || overflow) begin
				// end of line or overlong line: start fresh
				cnt_q       <= '0;
				dollar_q    <= 1'b0;
				star_q      <= 1'b0;
				xor_q       <= '0;
				talk_q[0]   <= '0;
				talk_q[1]   <= '0;
				type_q[0]   <= '0;
				type_q[1]   <= '0;
				type_q[2]   <= '0;
				type_done_q <= 1'b0;
				comma_q     <= '0;
				hexv_q      <= '0;
				hexd_q      <= '0;
				hexstop_q   <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 8'd1;
				if (cnt_q == 8'd0) begin
					dollar_q <= (rx_byte == CH_DOLLAR);
				end else if (!star_q) begin
					if (rx_byte == CH_STAR) begin
						star_q <= 1'b1;
					end else begin
						xor_q <= xor_q ^ rx_byte;
						if (p == 8'd0) talk_q[0] <= rx_byte;
						if (p == 8'd1) talk_q[1] <= rx_byte;
						if (rx_byte == CH_COMMA) begin
							type_done_q <= 1'b1;
							if (comma_q != 8'hFF) comma_q <= comma_q + 8'd1;
						end else if (!type_done_q) begin
							case (p)
								8'd2:    type_q[0] <= rx_byte;
								8'd3:    type_q[1] <= rx_byte;
								8'd4:    type_q[2] <= rx_byte;
								default: ;
							endcase
						end
					end
				end else if (!hexstop_q) begin
					if (!hex[4]) begin
						hexstop_q <= 1'b1;
					end else begin
						hexv_q <= {hexv_q[3:0], hex[3:0]};
						if (hexd_q <= MAX_HEX_DIGITS) hexd_q <= hexd_q + 4'd1;
					end
				end
			end
		end
	end

	// digit count saturates one past the limit
	a_hexd_sat: assert property (@(posedge clk) disable iff (!arst_n)
		hexd_q <= MAX_HEX_DIGITS + 4'd1)
		else $error("hex digit count ran past saturation");

	// hex digits only collect after the star
	a_hex_after_star: assert property (@(posedge clk) disable iff (!arst_n)
		(hexd_q != 4'd0) |-> star_q)
		else $error("hex digits without a star");

	// a fresh line follows every emitted line
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(en && line_end) |=> (cnt_q == 8'd0))
		else $error("line state not cleared after line end");

endmodule

// ----- sv/nsv_out_fifo.sv -----
// ----------------------------------------------------------------------------
// nsv_out_fifo
// two-entry result queue that decouples the result stream from the byte path
// ----------------------------------------------------------------------------
module nsv_out_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nsv_pkg::res_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output nsv_pkg::res_t data
);
	import nsv_pkg::*;

	res_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full result queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("pop from empty result queue");

endmodule

// ----- sv/nmea_sentence_validator.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_validator
// checks received nmea 0183 sentences byte by byte and reports one result
// word per non-empty line
// ----------------------------------------------------------------------------
// The block takes one received character per cycle on the slave stream while
// it does not stall: a character is registered, then the line state is
// updated from it, so s_tready only drops when a line ends while both entries
// of the result queue are still waiting. CR is ignored, LF closes the line,
// and a line growing past max_line_len is thrown away without a result. For
// each non-empty line one result word is queued as its LF leaves the input
// register and follows older results onto the master stream, holding the
// status (too short, no leading '$', no '*', checksum mismatch, tested in
// that order, else ok), the talker and type characters, the field count,
// the line length and both checksums. max_line_len is written over the cfg
// channel, which is always ready; write it only while no line is in progress.
// ----------------------------------------------------------------------------
module nmea_sentence_validator (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [nsv_pkg::IN_TDATA_W-1:0]      s_tdata,  // [7:0] rx_byte
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [2:0] status, [10:3] talker_first, [18:11] talker_second,
	// [26:19] type_first, [34:27] type_second, [42:35] type_third,
	// [50:43] field_count, [58:51] line_length, [66:59] received_sum,
	// [74:67] computed_sum, [79:75] zero
	output logic [nsv_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [7:0]                          cfg_data  // max_line_len
);
	import nsv_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [7:0] max_len_q;

	logic       line_end;
	logic       advance;
	logic       fifo_full;
	logic       fifo_push;
	logic       fifo_pop;
	res_t       line_res;
	res_t       out_res;

	// config register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LINE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// byte moves on unless it closes a line and the result queue is full
	assign advance   = valid_s1 && !(line_end && fifo_full);
	assign s_tready  = !valid_s1 || advance;
	assign fifo_push = advance && line_end;
	assign fifo_pop  = m_tvalid && m_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
		end
	end

	// running line state and result formation
	nsv_line_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.rx_byte      (byte_s1),
		.max_line_len (max_len_q),
		.line_end     (line_end),
		.res          (line_res)
	);

	// result queue in front of the master stream
	nsv_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (line_res),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.valid     (m_tvalid),
		.data      (out_res)
	);

	assign m_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, out_res};

	// results only come from an LF byte
	a_push_on_lf: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> (byte_s1 == CH_LF))
		else $error("result pushed for a byte other than LF");

	// input only stalls while a byte is held
	a_stall_holds_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && line_end && fifo_full))
		else $error("input stalled without a blocked line end");

	// a stalled byte stays in place
	a_stall_keeps_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled input byte lost");

endmodule
